@@ sv/rsm_pkg.sv @@
package rsm_pkg;

   // Counts and row lengths never exceed 64, so seven bits hold them
   localparam int CNT_W = 7;
   localparam int SAMPLE_W = 16;
   localparam int PROB_W = 16;
   localparam int SUM_W = 32;
   localparam int LOG2E_Q16 = 94548;
   localparam int EXP_CLAMP_HI = 32768;

   // One finished row handed from the front to the back
   typedef struct packed {
      logic             bank;
      logic [CNT_W-1:0] count;
   } job_type;

   // Back tells the front that a bank may be refilled
   typedef struct packed {
      logic valid;
      logic bank;
   } release_type;

   // 2^(i/16) in Q16
   function automatic logic [17:0] pow2_frac(input logic [4:0] idx);
      logic [17:0] val;
      case (idx)
         5'd0:  val = 18'd65536;
         5'd1:  val = 18'd68438;
         5'd2:  val = 18'd71468;
         5'd3:  val = 18'd74632;
         5'd4:  val = 18'd77936;
         5'd5:  val = 18'd81386;
         5'd6:  val = 18'd84990;
         5'd7:  val = 18'd88753;
         5'd8:  val = 18'd92682;
         5'd9:  val = 18'd96785;
         5'd10: val = 18'd101070;
         5'd11: val = 18'd105545;
         5'd12: val = 18'd110218;
         5'd13: val = 18'd115098;
         5'd14: val = 18'd120194;
         5'd15: val = 18'd125515;
         5'd16: val = 18'd131072;
         default: val = 18'd131072;
      endcase
      return val;
   endfunction

endpackage

@@ sv/rsm_ram.sv @@
module rsm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one word, read one word registered
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/rsm_queue.sv @@
module rsm_queue
   import rsm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output logic    head_valid,
   output job_type head_job
);

   job_type    slot_ff [2];
   job_type    slot_in [2];
   logic [1:0] used_ff, used_in;

   // Two-entry queue, head always in slot 0
   always_comb begin
      slot_in = slot_ff;
      used_in = used_ff;
      if (pop && used_ff != 2'd0) begin
         slot_in[0] = slot_ff[1];
         used_in = used_ff - 2'd1;
      end
      if (push) begin
         slot_in[used_in[0]] = push_job;
         used_in = used_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= 2'd0;
      end else begin
         used_ff <= used_in;
      end
      slot_ff <= slot_in;
   end

   assign head_valid = (used_ff != 2'd0);
   assign head_job = slot_ff[0];

endmodule

@@ sv/rsm_front.sv @@
module rsm_front
   import rsm_pkg::*;
#(
   parameter int ROW_MAX = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [SAMPLE_W-1:0]              req_sample,
   input  logic                             csr_write,
   input  logic [CNT_W-1:0]                 csr_data,
   input  release_type                      rel,
   output logic                             ram_wr_en,
   output logic [$clog2(2*ROW_MAX)-1:0]     ram_wr_addr,
   output logic [SAMPLE_W-1:0]              ram_wr_data,
   output logic                             job_push,
   output job_type                          job
);

   localparam int ADDR_W = $clog2(2*ROW_MAX);
   localparam int IDX_W = $clog2(ROW_MAX);

   logic [CNT_W-1:0] row_length_ff, row_length_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic             bank_ff, bank_in;
   logic [1:0]       busy_ff, busy_in;
   logic [CNT_W-1:0] len;
   logic [CNT_W-1:0] fill_next;
   logic             accept;

   // Clamp the configured length into 1..ROW_MAX
   always_comb begin
      len = row_length_ff;
      if (row_length_ff == '0) begin
         len = CNT_W'(1);
      end else if (row_length_ff > CNT_W'(ROW_MAX)) begin
         len = CNT_W'(ROW_MAX);
      end
   end

   // Hold off while the current bank is still owned by the back
   assign req_stall = busy_ff[bank_ff];
   assign accept = req_valid && !req_stall;
   assign fill_next = fill_ff + CNT_W'(1);

   assign ram_wr_en = accept;
   assign ram_wr_addr = (bank_ff ? ADDR_W'(ROW_MAX) : ADDR_W'(0))
                        + ADDR_W'(fill_ff[IDX_W-1:0]);
   assign ram_wr_data = req_sample;

   assign job_push = accept && (fill_next >= len);
   assign job.bank = bank_ff;
   assign job.count = fill_next;

   // Advance the fill count, close rows and track bank ownership
   always_comb begin
      row_length_in = csr_write ? csr_data : row_length_ff;
      fill_in = fill_ff;
      bank_in = bank_ff;
      busy_in = busy_ff;
      if (rel.valid) begin
         busy_in[rel.bank] = 1'b0;
      end
      if (accept) begin
         if (job_push) begin
            fill_in = '0;
            bank_in = !bank_ff;
            busy_in[bank_ff] = 1'b1;
         end else begin
            fill_in = fill_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_length_ff <= CNT_W'(64);
         fill_ff <= '0;
         bank_ff <= 1'b0;
         busy_ff <= 2'b00;
      end else begin
         row_length_ff <= row_length_in;
         fill_ff <= fill_in;
         bank_ff <= bank_in;
         busy_ff <= busy_in;
      end
   end

endmodule

@@ sv/rsm_back.sv @@
module rsm_back
   import rsm_pkg::*;
#(
   parameter int ROW_MAX = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         job_valid,
   input  job_type                      job,
   output logic                         job_pop,
   output logic [$clog2(2*ROW_MAX)-1:0] ram_rd_addr,
   input  logic [SAMPLE_W-1:0]          ram_rd_data,
   output release_type                  rel,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [PROB_W-1:0]            rsp_probability,
   output logic                         rsp_last_of_row
);

   localparam int ADDR_W = $clog2(2*ROW_MAX);
   localparam int IDX_W = $clog2(ROW_MAX);

   typedef enum logic [2:0] {
      B_IDLE, B_RDJ, B_LATJ, B_SWEEP, B_DRAIN, B_DIV, B_OUT
   } state_type;

   state_type          state_ff, state_in;
   logic               bank_ff, bank_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [CNT_W-1:0]   j_ff, j_in;
   logic [CNT_W-1:0]   k_ff, k_in;
   logic [SAMPLE_W-1:0] xj_ff, xj_in;
   logic [SUM_W-1:0]   acc_ff, acc_in;
   logic [SUM_W:0]     num_ff, num_in;
   logic [SUM_W:0]     rem_ff, rem_in;
   logic [SUM_W:0]     quo_ff, quo_in;
   logic [5:0]         step_ff, step_in;
   logic               out_valid_ff, out_valid_in;
   logic [PROB_W-1:0]  out_prob_ff, out_prob_in;
   logic               out_last_ff, out_last_in;

   // Exp pipeline registers
   logic               rd_vld_ff, d_vld_ff, p_vld_ff, m_vld_ff;
   logic               issue;
   logic signed [16:0] d_ff;
   logic signed [34:0] prod_ff;
   logic [17:0]        m_ff;
   logic signed [6:0]  n_ff;

   logic signed [16:0] d_raw, d_clamp;
   logic signed [34:0] prod;
   logic [18:0]        t_bits;
   logic [3:0]         fi;
   logic [7:0]         fw;
   logic [17:0]        ti, ti1, tdiff;
   logic [25:0]        interp;
   logic [17:0]        m_val;
   logic [6:0]         n_neg;
   logic [SUM_W-1:0]   term;
   logic [SUM_W:0]     acc_sum;
   logic [SUM_W:0]     div_r;
   logic               div_ge;
   logic [IDX_W-1:0]   rd_idx;

   // Difference x_k - x_j, clamped above at +8.0
   always_comb begin
      d_raw = 17'(signed'(ram_rd_data)) - 17'(signed'(xj_ff));
      d_clamp = (d_raw > 17'sd32768) ? 17'sd32768 : d_raw;
   end

   assign prod = 35'(d_ff) * 35'(signed'({1'b0, 17'(LOG2E_Q16)}));

   // Split into integer and fraction of the base-2 exponent, interpolate
   always_comb begin
      t_bits = prod_ff[34:16];
      fi = t_bits[11:8];
      fw = t_bits[7:0];
      ti = pow2_frac({1'b0, fi});
      ti1 = pow2_frac(5'({1'b0, fi}) + 5'd1);
      tdiff = ti1 - ti;
      interp = 26'(tdiff) * 26'(fw) + 26'd128;
      m_val = ti + 18'(interp[25:8]);
   end

   // Scale by 2^n
   always_comb begin
      n_neg = 7'(-n_ff);
      if (!n_ff[6]) begin
         term = SUM_W'(m_ff) << n_ff[3:0];
      end else if (n_neg >= 7'd32) begin
         term = '0;
      end else begin
         term = SUM_W'(m_ff) >> n_neg[4:0];
      end
      acc_sum = {1'b0, acc_ff} + {1'b0, term};
   end

   // One restoring divide step
   always_comb begin
      div_r = {rem_ff[SUM_W-1:0], num_ff[SUM_W]};
      div_ge = (div_r >= {1'b0, acc_ff});
   end

   assign rd_idx = (state_ff == B_SWEEP) ? k_ff[IDX_W-1:0] : j_ff[IDX_W-1:0];
   assign ram_rd_addr = (bank_ff ? ADDR_W'(ROW_MAX) : ADDR_W'(0)) + ADDR_W'(rd_idx);
   assign issue = (state_ff == B_SWEEP);
   assign job_pop = (state_ff == B_IDLE) && job_valid;

   // Sequence one row: per element read x_j, sweep all x_k, divide, emit
   always_comb begin
      state_in = state_ff;
      bank_in = bank_ff;
      cnt_in = cnt_ff;
      j_in = j_ff;
      k_in = k_ff;
      xj_in = xj_ff;
      acc_in = acc_ff;
      num_in = num_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      step_in = step_ff;
      out_valid_in = out_valid_ff;
      out_prob_in = out_prob_ff;
      out_last_in = out_last_ff;
      rel.valid = 1'b0;
      rel.bank = bank_ff;
      if (m_vld_ff) begin
         acc_in = acc_sum[SUM_W] ? '1 : acc_sum[SUM_W-1:0];
      end
      case (state_ff)
         B_IDLE: begin
            if (job_valid) begin
               bank_in = job.bank;
               cnt_in = job.count;
               j_in = '0;
               state_in = B_RDJ;
            end
         end
         B_RDJ: begin
            state_in = B_LATJ;
         end
         B_LATJ: begin
            xj_in = ram_rd_data;
            acc_in = '0;
            k_in = '0;
            state_in = B_SWEEP;
         end
         B_SWEEP: begin
            k_in = k_ff + CNT_W'(1);
            if (k_ff == cnt_ff - CNT_W'(1)) begin
               state_in = B_DRAIN;
            end
         end
         B_DRAIN: begin
            if (!rd_vld_ff && !d_vld_ff && !p_vld_ff && !m_vld_ff) begin
               num_in = {1'b1, SUM_W'(0)} + {2'b00, acc_ff[SUM_W-1:1]};
               rem_in = '0;
               quo_in = '0;
               step_in = '0;
               state_in = B_DIV;
            end
         end
         B_DIV: begin
            rem_in = div_ge ? div_r - {1'b0, acc_ff} : div_r;
            quo_in = {quo_ff[SUM_W-1:0], div_ge};
            num_in = num_ff << 1;
            step_in = step_ff + 6'd1;
            if (step_ff == 6'(SUM_W)) begin
               out_valid_in = 1'b1;
               out_prob_in = (|quo_in[SUM_W:PROB_W]) ? '1 : quo_in[PROB_W-1:0];
               out_last_in = (j_ff + CNT_W'(1) == cnt_ff);
               state_in = B_OUT;
            end
         end
         B_OUT: begin
            if (!rsp_stall) begin
               out_valid_in = 1'b0;
               j_in = j_ff + CNT_W'(1);
               if (out_last_ff) begin
                  rel.valid = 1'b1;
                  state_in = B_IDLE;
               end else begin
                  state_in = B_RDJ;
               end
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         out_valid_ff <= 1'b0;
         rd_vld_ff <= 1'b0;
         d_vld_ff <= 1'b0;
         p_vld_ff <= 1'b0;
         m_vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         out_valid_ff <= out_valid_in;
         rd_vld_ff <= issue;
         d_vld_ff <= rd_vld_ff;
         p_vld_ff <= d_vld_ff;
         m_vld_ff <= p_vld_ff;
      end
      bank_ff <= bank_in;
      cnt_ff <= cnt_in;
      j_ff <= j_in;
      k_ff <= k_in;
      xj_ff <= xj_in;
      acc_ff <= acc_in;
      num_ff <= num_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      step_ff <= step_in;
      out_prob_ff <= out_prob_in;
      out_last_ff <= out_last_in;
      d_ff <= d_clamp;
      prod_ff <= prod;
      m_ff <= m_val;
      n_ff <= signed'(t_bits[18:12]);
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_probability = out_prob_ff;
   assign rsp_last_of_row = out_last_ff;

endmodule

@@ sv/row_softmax.sv @@
// Row softmax: Q4.12 samples are stored into one of two row banks; when a
// row of csr row_length samples (0 acts as 1, above ROW_MAX as ROW_MAX) is
// complete, it is queued and the back end emits one Q0.16 probability per
// element, 1 / sum_k exp(x_k - x_j), in row order with last_of_row on the
// final word. In the back end each element reads x_j, sweeps the whole row
// through one exp pipeline (one term a cycle) and waits for it to drain,
// runs a 33-step bit-serial divider and presents its word until it is
// taken. The front keeps taking samples for the next row in the other bank,
// so it stalls only when both banks are awaiting the back end.
module row_softmax
   import rsm_pkg::*;
#(
   parameter int ROW_MAX = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [SAMPLE_W-1:0] req_sample,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [PROB_W-1:0]   rsp_probability,
   output logic                rsp_last_of_row,
   input  logic                csr_write,
   input  logic [CNT_W-1:0]    csr_data
);

   localparam int ADDR_W = $clog2(2*ROW_MAX);

   logic                ram_wr_en;
   logic [ADDR_W-1:0]   ram_wr_addr;
   logic [SAMPLE_W-1:0] ram_wr_data;
   logic [ADDR_W-1:0]   ram_rd_addr;
   logic [SAMPLE_W-1:0] ram_rd_data;
   logic                job_push, job_pop, head_valid;
   job_type             push_job, head_job;
   release_type         rel;

   rsm_front #(.ROW_MAX(ROW_MAX)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_sample  (req_sample),
      .csr_write   (csr_write),
      .csr_data    (csr_data),
      .rel         (rel),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .job_push    (job_push),
      .job         (push_job)
   );

   rsm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (job_push),
      .push_job   (push_job),
      .pop        (job_pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   rsm_ram #(.WIDTH(SAMPLE_W), .DEPTH(2*ROW_MAX)) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   rsm_back #(.ROW_MAX(ROW_MAX)) u_back (
      .clock           (clock),
      .reset           (reset),
      .job_valid       (head_valid),
      .job             (head_job),
      .job_pop         (job_pop),
      .ram_rd_addr     (ram_rd_addr),
      .ram_rd_data     (ram_rd_data),
      .rel             (rel),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_probability (rsp_probability),
      .rsp_last_of_row (rsp_last_of_row)
   );

endmodule
